[rtl/nmz_pkg.sv]
// Shared constants, control struct and helper functions for the neighbourhood
// majority zone block. No dependencies.
package nmz_pkg;

   localparam int ROW_WIDTH  = 64;
   localparam int GRID_CELLS = 4096;
   localparam int ADDR_W     = $clog2(GRID_CELLS);
   localparam int CELL_W     = 12;
   localparam int LABEL_W    = 5;
   localparam int BITS_W     = 16;
   localparam int ZONE_COUNT = 17;
   localparam int ZONE_MAX   = 16;
   localparam int CNT_W      = 4;
   localparam int STEP_W     = 4;
   localparam int NBR_COUNT  = 9;
   localparam int REACH      = ROW_WIDTH + 1;
   localparam int CHK_W      = ((ADDR_W > CELL_W) ? ADDR_W : CELL_W) + 2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic               clear;
      logic               add;
      logic [LABEL_W-1:0] label;
   } tally_ctl_type;

   // Offset of each neighborhood read, modulo the address space
   function automatic logic [ADDR_W-1:0] nbr_offset(input logic [STEP_W-1:0] step);
      logic [ADDR_W-1:0] off;
      unique case (step)
         STEP_W'(0): off = '0;
         STEP_W'(1): off = ADDR_W'(1);
         STEP_W'(2): off = ADDR_W'(-1);
         STEP_W'(3): off = ADDR_W'(ROW_WIDTH - 1);
         STEP_W'(4): off = ADDR_W'(-(ROW_WIDTH - 1));
         STEP_W'(5): off = ADDR_W'(ROW_WIDTH);
         STEP_W'(6): off = ADDR_W'(-ROW_WIDTH);
         STEP_W'(7): off = ADDR_W'(ROW_WIDTH + 1);
         STEP_W'(8): off = ADDR_W'(-(ROW_WIDTH + 1));
         default:    off = '0;
      endcase
      return off;
   endfunction

   function automatic logic [BITS_W-1:0] zone_to_bits(input logic [LABEL_W-1:0] zone);
      logic [BITS_W-1:0] bits;
      if (zone == '0 || zone > LABEL_W'(ZONE_MAX)) begin
         bits = '0;
      end else begin
         bits = BITS_W'(1) << (zone - LABEL_W'(1));
      end
      return bits;
   endfunction

endpackage

[rtl/nmz_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module nmz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/nmz_tally.sv]
// Label histogram with a running mode (lowest label wins ties).
// Depends on nmz_pkg.
module nmz_tally (
   input  logic                       clock,
   input  nmz_pkg::tally_ctl_type     ctl,
   output logic [nmz_pkg::LABEL_W-1:0] zone
);

   logic [nmz_pkg::CNT_W-1:0]   count_ff [nmz_pkg::ZONE_COUNT];
   logic [nmz_pkg::CNT_W-1:0]   best_ff;
   logic [nmz_pkg::LABEL_W-1:0] zone_ff;
   logic                        label_ok;
   logic [nmz_pkg::CNT_W-1:0]   bump;

   always_comb begin
      label_ok = ctl.label < nmz_pkg::LABEL_W'(nmz_pkg::ZONE_COUNT);
      bump     = label_ok ? count_ff[ctl.label] + nmz_pkg::CNT_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         for (int i = 0; i < nmz_pkg::ZONE_COUNT; i++) begin
            count_ff[i] <= '0;
         end
         best_ff <= '0;
         zone_ff <= '0;
      end else if (ctl.add && label_ok) begin
         count_ff[ctl.label] <= bump;
         // only the bumped bin can overtake the current leader
         if (bump > best_ff || (bump == best_ff && ctl.label < zone_ff)) begin
            best_ff <= bump;
            zone_ff <= ctl.label;
         end
      end
   end

   assign zone = zone_ff;

endmodule

[rtl/neighbourhood_majority_zone.sv]
// Query: busy from accept through the READ, DRAIN and EMIT states; the result strobes once
// the last of nine single-port grid reads is tallied in DRAIN and the mode is registered in EMIT.
// Writes and edge queries keep the block idle; the result strobes in the next cycle.
// After reset the grid is cleared one cell per cycle, with busy high.
// Results cannot be stalled by the receiver. Depends on nmz_pkg, nmz_ram, nmz_tally.
module neighbourhood_majority_zone (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [nmz_pkg::CELL_W-1:0]   req_cell_index,
   input  logic [nmz_pkg::LABEL_W-1:0]  req_zone_label,
   output logic                         rsp_strobe,
   output logic [nmz_pkg::BITS_W-1:0]   rsp_zone_bits,
   output logic                         rsp_out_of_range
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [nmz_pkg::ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [nmz_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [nmz_pkg::ADDR_W-1:0]   center_ff, center_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic                         strobe_ff, strobe_in;
   logic [nmz_pkg::BITS_W-1:0]   bits_ff, bits_in;
   logic                         oor_ff, oor_in;

   logic                         accept;
   logic                         is_query;
   logic [nmz_pkg::CHK_W-1:0]    cell_ext;
   logic                         near_edge;
   logic                         cell_ok;
   logic [nmz_pkg::LABEL_W-1:0]  label_sat;

   logic                         ram_we;
   logic [nmz_pkg::ADDR_W-1:0]   ram_addr;
   logic [nmz_pkg::LABEL_W-1:0]  ram_wr_data;
   logic [nmz_pkg::LABEL_W-1:0]  ram_rd_data;

   nmz_pkg::tally_ctl_type       tally_ctl;
   logic [nmz_pkg::LABEL_W-1:0]  zone;

   always_comb begin
      busy      = state_ff != ST_IDLE;
      accept    = start && !busy;
      is_query  = req_opcode == nmz_pkg::OP_QUERY;
      cell_ext  = nmz_pkg::CHK_W'(req_cell_index);
      near_edge = cell_ext < nmz_pkg::CHK_W'(nmz_pkg::REACH)
               || cell_ext + nmz_pkg::CHK_W'(nmz_pkg::REACH)
                  >= nmz_pkg::CHK_W'(nmz_pkg::GRID_CELLS);
      cell_ok   = cell_ext < nmz_pkg::CHK_W'(nmz_pkg::GRID_CELLS);
      label_sat = (req_zone_label > nmz_pkg::LABEL_W'(nmz_pkg::ZONE_MAX))
                ? nmz_pkg::LABEL_W'(nmz_pkg::ZONE_MAX) : req_zone_label;
   end

   // single memory port: clearing sweep, neighborhood reads, or request writes
   always_comb begin
      priority if (state_ff == ST_CLEAR) begin
         ram_we      = 1'b1;
         ram_addr    = clr_addr_ff;
         ram_wr_data = '0;
      end else if (state_ff == ST_READ) begin
         ram_we      = 1'b0;
         ram_addr    = center_ff + nmz_pkg::nbr_offset(step_ff);
         ram_wr_data = '0;
      end else begin
         ram_we      = accept && !is_query && cell_ok;
         ram_addr    = nmz_pkg::ADDR_W'(req_cell_index);
         ram_wr_data = label_sat;
      end
   end

   nmz_ram #(
      .WIDTH (nmz_pkg::LABEL_W),
      .DEPTH (nmz_pkg::GRID_CELLS)
   ) u_grid (
      .clock   (clock),
      .we      (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      tally_ctl.clear = accept && is_query && !near_edge;
      tally_ctl.add   = rd_pend_ff;
      tally_ctl.label = ram_rd_data;
   end

   nmz_tally u_tally (
      .clock (clock),
      .ctl   (tally_ctl),
      .zone  (zone)
   );

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      step_in     = step_ff;
      center_in   = center_ff;
      rd_pend_in  = state_ff == ST_READ;
      strobe_in   = 1'b0;
      bits_in     = bits_ff;
      oor_in      = oor_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + nmz_pkg::ADDR_W'(1);
            if (clr_addr_ff == nmz_pkg::ADDR_W'(nmz_pkg::GRID_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (is_query && !near_edge) begin
                  state_in  = ST_READ;
                  step_in   = '0;
                  center_in = nmz_pkg::ADDR_W'(req_cell_index);
               end else begin
                  // writes and edge queries answer at once
                  strobe_in = 1'b1;
                  bits_in   = '0;
                  oor_in    = is_query;
               end
            end
         end
         ST_READ: begin
            step_in = step_ff + nmz_pkg::STEP_W'(1);
            if (step_ff == nmz_pkg::STEP_W'(nmz_pkg::NBR_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            bits_in   = nmz_pkg::zone_to_bits(zone);
            oor_in    = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         step_ff     <= '0;
         rd_pend_ff  <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         step_ff     <= step_in;
         rd_pend_ff  <= rd_pend_in;
         strobe_ff   <= strobe_in;
      end
      center_ff <= center_in;
      bits_ff   <= bits_in;
      oor_ff    <= oor_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_zone_bits    = bits_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

[tb/nmz_checker.sv]
// Response checker for neighbourhood_majority_zone: mirrors the zone grid from
// accepted requests, predicts every response and compares it. Depends on nmz_pkg.
module nmz_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        req_opcode,
   input  logic [nmz_pkg::CELL_W-1:0]  req_cell_index,
   input  logic [nmz_pkg::LABEL_W-1:0] req_zone_label,
   input  logic                        rsp_strobe,
   input  logic [nmz_pkg::BITS_W-1:0]  rsp_zone_bits,
   input  logic                        rsp_out_of_range,
   output int                          error_count,
   output int                          pending_count,
   output int                          write_count,
   output int                          query_count,
   output int                          edge_count,
   output int                          majority_count
);
   import nmz_pkg::*;

   typedef struct packed {
      logic [BITS_W-1:0] zone_bits;
      logic              out_of_range;
   } zone_result_type;

   logic [LABEL_W-1:0] zone_map [GRID_CELLS];
   zone_result_type    awaited_q [$];
   int                 err_tally = 0;
   int                 resp_seen = 0;
   int                 n_write = 0;
   int                 n_query = 0;
   int                 n_edge = 0;
   int                 n_major = 0;

   // Mode of the 3x3 neighborhood, ties to the lowest zone, returned one-hot
   function automatic logic [BITS_W-1:0] majority_bits(input int center);
      int tally [ZONE_COUNT];
      int reach_off [4];
      int best_cnt;
      int best_zone;
      int z;
      reach_off = '{1, ROW_WIDTH - 1, ROW_WIDTH, ROW_WIDTH + 1};
      foreach (tally[i]) tally[i] = 0;
      tally[zone_map[center]]++;
      foreach (reach_off[k]) begin
         tally[zone_map[center + reach_off[k]]]++;
         tally[zone_map[center - reach_off[k]]]++;
      end
      best_cnt = 0;
      best_zone = 0;
      for (z = 0; z < ZONE_COUNT; z++) begin
         if (tally[z] > best_cnt) begin
            best_cnt = tally[z];
            best_zone = z;
         end
      end
      if (best_zone == 0) return '0;
      return BITS_W'(1) << (best_zone - 1);
   endfunction

   task automatic report_mismatch(input string what, input int exp_v, input int got_v);
      $display("mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
               resp_seen, what, exp_v, got_v);
      err_tally++;
   endtask

   always @(posedge clock) begin : watch
      zone_result_type want;
      int              pos;
      if (reset) begin
         awaited_q.delete();
         foreach (zone_map[i]) zone_map[i] = '0;
      end else begin
         // Retire first: a response never belongs to a request accepted at the same edge
         if (rsp_strobe) begin
            if (awaited_q.size() == 0) begin
               report_mismatch("response with no request pending", 0, rsp_zone_bits);
            end else begin
               want = awaited_q.pop_front();
               if (rsp_zone_bits !== want.zone_bits) begin
                  report_mismatch("zone_bits", want.zone_bits, rsp_zone_bits);
               end
               if (rsp_out_of_range !== want.out_of_range) begin
                  report_mismatch("out_of_range", want.out_of_range, rsp_out_of_range);
               end
            end
            resp_seen++;
         end
         if (start && !busy) begin
            pos = int'(req_cell_index);
            want.zone_bits = '0;
            want.out_of_range = 1'b0;
            if (req_opcode == OP_WRITE) begin
               // Saturate labels above the top zone
               zone_map[pos] = (req_zone_label > ZONE_MAX) ? LABEL_W'(ZONE_MAX) : req_zone_label;
               n_write++;
            end else if (pos < REACH || pos + REACH >= GRID_CELLS) begin
               want.out_of_range = 1'b1;
               n_query++;
               n_edge++;
            end else begin
               want.zone_bits = majority_bits(pos);
               n_query++;
               if (want.zone_bits != '0) n_major++;
            end
            awaited_q.push_back(want);
         end
      end
      pending_count  <= awaited_q.size();
      error_count    <= err_tally;
      write_count    <= n_write;
      query_count    <= n_query;
      edge_count     <= n_edge;
      majority_count <= n_major;
   end

endmodule

[tb/neighbourhood_majority_zone_tb.sv]
// Testbench top for neighbourhood_majority_zone: drives write and query requests with
// random gaps and gives the verdict. Depends on nmz_pkg, nmz_checker and the block.
module neighbourhood_majority_zone_tb;
   import nmz_pkg::*;

   localparam int ITEM_TARGET = 1850;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 16;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_opcode = OP_WRITE;
   logic [CELL_W-1:0]   req_cell_index = '0;
   logic [LABEL_W-1:0]  req_zone_label = '0;
   logic                rsp_strobe;
   logic [BITS_W-1:0]   rsp_zone_bits;
   logic                rsp_out_of_range;

   int                  error_count;
   int                  pending_count;
   int                  write_count;
   int                  query_count;
   int                  edge_count;
   int                  majority_count;
   int                  sent_count = 0;
   int unsigned         cycle_count = 0;
   bit                  steady_stream = 1'b0;
   int                  nbr_off [9] = '{0, 1, -1, ROW_WIDTH - 1, -(ROW_WIDTH - 1),
                                        ROW_WIDTH, -ROW_WIDTH, ROW_WIDTH + 1, -(ROW_WIDTH + 1)};

   neighbourhood_majority_zone i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_cell_index   (req_cell_index),
      .req_zone_label   (req_zone_label),
      .rsp_strobe       (rsp_strobe),
      .rsp_zone_bits    (rsp_zone_bits),
      .rsp_out_of_range (rsp_out_of_range)
   );

   nmz_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_cell_index   (req_cell_index),
      .req_zone_label   (req_zone_label),
      .rsp_strobe       (rsp_strobe),
      .rsp_zone_bits    (rsp_zone_bits),
      .rsp_out_of_range (rsp_out_of_range),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .write_count      (write_count),
      .query_count      (query_count),
      .edge_count       (edge_count),
      .majority_count   (majority_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still pending", cycle_count,
                  pending_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady_stream) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Call at a rising edge; returns at the edge that accepts the request or ends its gap
   task automatic issue(input logic op, input int pos, input int label);
      int gap;
      start          <= 1'b1;
      req_opcode     <= op;
      req_cell_index <= CELL_W'(pos);
      req_zone_label <= LABEL_W'(label);
      do @(posedge clock); while (busy);
      sent_count++;
      gap = pick_gap();
      if (gap > 0) begin
         // Drop start and scramble the idle fields
         start          <= 1'b0;
         req_opcode     <= 1'($urandom_range(0, 1));
         req_cell_index <= CELL_W'($urandom);
         req_zone_label <= LABEL_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic directed_requests();
      int k;
      // Fresh grid and the borders of the legal query range
      issue(OP_QUERY, REACH, 0);
      issue(OP_QUERY, REACH - 1, 31);
      issue(OP_QUERY, 0, 0);
      issue(OP_QUERY, GRID_CELLS - REACH - 1, 0);
      issue(OP_QUERY, GRID_CELLS - REACH, 0);
      issue(OP_QUERY, GRID_CELLS - 1, 0);
      issue(OP_WRITE, 0, 31);
      issue(OP_WRITE, GRID_CELLS - 1, ZONE_MAX);
      issue(OP_QUERY, GRID_CELLS - REACH - 1, 0);
      // Five saturating labels around one cell: top zone wins
      for (k = 0; k < 5; k++) issue(OP_WRITE, 2000 + nbr_off[k], 17 + k);
      issue(OP_QUERY, 2000, 0);
      // Four against four between zones 1 and 5: lower zone wins the tie
      for (k = 1; k < 9; k++) issue(OP_WRITE, 3000 + nbr_off[k], (k % 2) ? 5 : 1);
      issue(OP_QUERY, 3000, 0);
   endtask

   // Paint a few neighbors of one cell from a small label set, then query it and sometimes a neighbor
   task automatic neighbourhood_burst();
      int center;
      int writes;
      int palette [3];
      center = $urandom_range(REACH, GRID_CELLS - REACH - 1);
      foreach (palette[p]) begin
         palette[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, ZONE_MAX);
      end
      writes = $urandom_range(1, 9);
      repeat (writes) begin
         issue(OP_WRITE, center + nbr_off[$urandom_range(0, 8)], palette[$urandom_range(0, 2)]);
      end
      issue(OP_QUERY, center, $urandom_range(0, 31));
      if ($urandom_range(0, 2) == 0) begin
         issue(OP_QUERY, center + nbr_off[$urandom_range(1, 8)], $urandom_range(0, 31));
      end
   endtask

   task automatic random_requests();
      int base;
      int pick;
      int pos;
      base = sent_count;
      while (sent_count - base < ITEM_TARGET) begin
         if (steady_stream) steady_stream = ($urandom_range(0, 3) != 0);
         else steady_stream = ($urandom_range(0, 11) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            neighbourhood_burst();
         end else if (pick < 82) begin
            issue(OP_WRITE, $urandom_range(0, GRID_CELLS - 1), $urandom_range(0, 31));
         end else if (pick < 92) begin
            issue(OP_QUERY, $urandom_range(0, GRID_CELLS - 1), $urandom_range(0, 31));
         end else if (pick < 98) begin
            pos = $urandom_range(0, 1) ? $urandom_range(0, REACH + 2)
                                       : $urandom_range(GRID_CELLS - REACH - 3, GRID_CELLS - 1);
            issue(OP_QUERY, pos, $urandom_range(0, 31));
         end else begin
            drain_responses();
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      directed_requests();
      drain_responses();
      random_requests();
      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d requests: %0d writes, %0d queries", sent_count, write_count,
               query_count);
      $display("%0d queries hit the grid edge, %0d found a nonzero majority zone", edge_count,
               majority_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
